// ===== src/fdt_pkg.sv =====
// Shared constants for the device-tree structure block token parser:
// parse modes, token codes, event codes and a zero-byte test. No dependencies.
package fdt_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned EventW  = 3;
  localparam int unsigned ModeW   = 3;
  localparam int unsigned CountW  = 30;
  localparam int unsigned TdataOW = 96;  // value_word, prop_length, name_offset

  // parse modes
  localparam logic [ModeW-1:0] ModeToken   = 3'd0;
  localparam logic [ModeW-1:0] ModeName    = 3'd1;
  localparam logic [ModeW-1:0] ModeLen     = 3'd2;
  localparam logic [ModeW-1:0] ModeNameOff = 3'd3;
  localparam logic [ModeW-1:0] ModeValue   = 3'd4;
  localparam logic [ModeW-1:0] ModeHalt    = 3'd5;

  // structure block tokens
  localparam logic [WordW-1:0] TokBeginNode = 32'd1;
  localparam logic [WordW-1:0] TokEndNode   = 32'd2;
  localparam logic [WordW-1:0] TokProp      = 32'd3;
  localparam logic [WordW-1:0] TokNop       = 32'd4;
  localparam logic [WordW-1:0] TokEnd       = 32'd9;

  // events
  localparam logic [EventW-1:0] EvConsumed = 3'd0;
  localparam logic [EventW-1:0] EvBegin    = 3'd1;
  localparam logic [EventW-1:0] EvEndNode  = 3'd2;
  localparam logic [EventW-1:0] EvHeader   = 3'd3;
  localparam logic [EventW-1:0] EvValue    = 3'd4;
  localparam logic [EventW-1:0] EvEnd      = 3'd5;
  localparam logic [EventW-1:0] EvNop      = 3'd6;
  localparam logic [EventW-1:0] EvError    = 3'd7;

  function automatic logic has_zero_byte(input logic [WordW-1:0] w);
    return (w[31:24] == 8'h00) || (w[23:16] == 8'h00) ||
           (w[15:8] == 8'h00) || (w[7:0] == 8'h00);
  endfunction

endpackage

// ===== src/fdt_struct_token_parser.sv =====
// Device-tree structure block token parser, top level.
// Depends on fdt_pkg for mode, token and event codes.
//
// Takes one 32-bit structure block word per request (first memory byte in
// bits 31..24) and returns exactly one event per word through a single
// output register. A new word is taken every cycle as long as the output
// register is empty or being drained, so throughput is one word per clock.
// Property length and name offset are carried on header and value events;
// the final value word of a property has tlast set. An unknown token
// reports an error and every later word is consumed silently until reset.
module fdt_struct_token_parser (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [31:0]  s_axis_tdata,   // [31:0] word
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [95:0]  m_axis_tdata,   // [31:0] value_word, [63:32] prop_length,
                                       // [95:64] name_offset
  output logic [2:0]   m_axis_tuser,   // [2:0] event_res
  output logic         m_axis_tlast    // last_value
);

  logic [fdt_pkg::ModeW-1:0]  mode_q, mode_d;
  logic [fdt_pkg::CountW-1:0] words_left_q, words_left_d;
  logic [fdt_pkg::WordW-1:0]  held_len_q, held_len_d;
  logic [fdt_pkg::WordW-1:0]  held_off_q, held_off_d;

  logic                        out_valid_q;
  logic [fdt_pkg::EventW-1:0]  ev_q, ev_d;
  logic [fdt_pkg::WordW-1:0]   val_q, val_d;
  logic [fdt_pkg::WordW-1:0]   plen_q, plen_d;
  logic [fdt_pkg::WordW-1:0]   poff_q, poff_d;
  logic                        last_q, last_d;

  logic                        in_fire;
  logic [fdt_pkg::WordW-1:0]   w;
  logic [fdt_pkg::WordW-1:0]   len_m1;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign w             = s_axis_tdata;
  assign len_m1        = held_len_q - 32'd1;

  always_comb begin
    mode_d       = mode_q;
    words_left_d = words_left_q;
    held_len_d   = held_len_q;
    held_off_d   = held_off_q;
    ev_d         = fdt_pkg::EvConsumed;
    val_d        = '0;
    plen_d       = '0;
    poff_d       = '0;
    last_d       = 1'b0;
    unique case (mode_q)
      fdt_pkg::ModeToken: begin
        priority if (w == fdt_pkg::TokBeginNode) begin
          ev_d   = fdt_pkg::EvBegin;
          mode_d = fdt_pkg::ModeName;
        end else if (w == fdt_pkg::TokEndNode) begin
          ev_d = fdt_pkg::EvEndNode;
        end else if (w == fdt_pkg::TokProp) begin
          mode_d = fdt_pkg::ModeLen;
        end else if (w == fdt_pkg::TokNop) begin
          ev_d = fdt_pkg::EvNop;
        end else if (w == fdt_pkg::TokEnd) begin
          ev_d = fdt_pkg::EvEnd;
        end else begin
          ev_d   = fdt_pkg::EvError;
          mode_d = fdt_pkg::ModeHalt;
        end
      end
      fdt_pkg::ModeName: begin
        if (fdt_pkg::has_zero_byte(w)) mode_d = fdt_pkg::ModeToken;
      end
      fdt_pkg::ModeLen: begin
        held_len_d = w;
        mode_d     = fdt_pkg::ModeNameOff;
      end
      fdt_pkg::ModeNameOff: begin
        held_off_d = w;
        ev_d       = fdt_pkg::EvHeader;
        plen_d     = held_len_q;
        poff_d     = w;
        if (held_len_q == '0) begin
          mode_d = fdt_pkg::ModeToken;
        end else begin
          // ceil(len/4) - 1 words follow the first
          words_left_d = len_m1[31:2];
          mode_d       = fdt_pkg::ModeValue;
        end
      end
      fdt_pkg::ModeValue: begin
        ev_d   = fdt_pkg::EvValue;
        val_d  = w;
        plen_d = held_len_q;
        poff_d = held_off_q;
        if (words_left_q == '0) begin
          last_d = 1'b1;
          mode_d = fdt_pkg::ModeToken;
        end else begin
          words_left_d = words_left_q - 30'd1;
        end
      end
      default: mode_d = fdt_pkg::ModeHalt;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= fdt_pkg::ModeToken;
      words_left_q <= '0;
      held_len_q   <= '0;
      held_off_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (in_fire) begin
        mode_q       <= mode_d;
        words_left_q <= words_left_d;
        held_len_q   <= held_len_d;
        held_off_q   <= held_off_d;
        out_valid_q  <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ev_q   <= ev_d;
      val_q  <= val_d;
      plen_q <= plen_d;
      poff_q <= poff_d;
      last_q <= last_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {poff_q, plen_q, val_q};
  assign m_axis_tuser  = ev_q;
  assign m_axis_tlast  = last_q;

`ifndef SYNTHESIS
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == fdt_pkg::ModeHalt |=> mode_q == fdt_pkg::ModeHalt)
    else $error("parser left halt without reset");

  a_count_in_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    words_left_q != '0 |-> mode_q == fdt_pkg::ModeValue)
    else $error("value word count pending outside value mode");

  a_last_is_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == fdt_pkg::EvValue)
    else $error("tlast on non-value event");

  a_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != fdt_pkg::EvValue |-> m_axis_tdata[31:0] == '0)
    else $error("value word nonzero on non-value event");

  a_halt_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && mode_q == fdt_pkg::ModeHalt |=> m_axis_tuser == fdt_pkg::EvConsumed)
    else $error("event reported while halted");
`endif

endmodule
